FILE: sv/d2ed_pkg.sv
// constants and month tables for the date to epoch day and weekday pipeline
// no dependencies; used by date_to_epoch_day_and_weekday_top
package d2ed_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DaysW  = 19;
  localparam int unsigned WdayW  = 3;

  localparam logic [YearW-1:0]  YEAR_MIN  = 12'd1600;
  localparam logic [YearW-1:0]  YEAR_MAX  = 12'd2500;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  // floor(x / 100) = (x * DIV100_MUL) >> 17 for x < 4681
  localparam logic [10:0] DIV100_MUL = 11'd1311;
  // floor(x / 7) = (x * DIV7_MUL) >> 22 for x < 838860
  localparam logic [19:0] DIV7_MUL   = 20'd599187;

  localparam logic [21:0] EPOCH_SHIFT = 22'd719468;
  // week bias plus thursday offset of the epoch
  localparam logic [18:0] WEEK_OFFSET = 19'd140003;

  // day of year counted from march 1 for the first day of each month
  function automatic logic [8:0] doy_base(input logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // month length in a common year
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/date_to_epoch_day_and_weekday_top.sv
// gregorian date to signed day count from 1970-01-01 and weekday, five stage pipeline
// depends on d2ed_pkg
//
//   channel  handshake               fields
//   in       in_valid / in_ready     year, month, day_of_month
//   out      out_valid / out_ready   date_ok, epoch_days, weekday
//
// one request per cycle sustained while out_ready stays high
// each stage holds one request and loads when it is empty or the next stage moves on
// stage 1 holds two multipliers for the divide by 100 and stage 4 one for the divide by 7
// a stall at the output backs up stage by stage, nothing is dropped or repeated
// rst is synchronous and clears only the stage valid bits
module date_to_epoch_day_and_weekday_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [d2ed_pkg::YearW-1:0]    year,
  input  logic [d2ed_pkg::MonthW-1:0]   month,
  input  logic [d2ed_pkg::DayW-1:0]     day_of_month,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          date_ok,
  output logic signed [d2ed_pkg::DaysW-1:0] epoch_days,
  output logic [d2ed_pkg::WdayW-1:0]    weekday
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: range checks, march based year, divide by 100 products, month length, day of year
  logic [11:0] s1_y, s1_yy;
  logic [22:0] s1_py, s1_pyy;
  logic        s1_rng_ok, s1_feb;
  logic [4:0]  s1_len, s1_d;
  logic [8:0]  s1_doy;
  logic [11:0] yy_in;

  assign yy_in = (month <= d2ed_pkg::MONTH_FEB) ? 12'(year - 12'd1) : year;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_y      <= year;
      s1_yy     <= yy_in;
      s1_py     <= 23'(year) * 23'(d2ed_pkg::DIV100_MUL);
      s1_pyy    <= 23'(yy_in) * 23'(d2ed_pkg::DIV100_MUL);
      s1_rng_ok <= (year >= d2ed_pkg::YEAR_MIN) && (year <= d2ed_pkg::YEAR_MAX) &&
                   (month >= d2ed_pkg::MONTH_JAN) && (month <= d2ed_pkg::MONTH_DEC);
      s1_feb    <= (month == d2ed_pkg::MONTH_FEB);
      s1_len    <= d2ed_pkg::month_days(month);
      s1_d      <= day_of_month;
      s1_doy    <= 9'(d2ed_pkg::doy_base(month) + 9'(day_of_month) - 9'd1);
    end
  end

  // stage 2: leap rule, validity, days of whole years
  logic [5:0]  q_y, q_yy;
  logic        leap;
  logic [4:0]  len;
  logic        s2_ok;
  logic [20:0] s2_y365;
  logic [9:0]  s2_yy4;
  logic [5:0]  s2_q;
  logic [8:0]  s2_doy;

  assign q_y  = s1_py[22:17];
  assign q_yy = s1_pyy[22:17];
  assign leap = (s1_y[1:0] == 2'd0) &&
                ((s1_y != 12'(q_y) * 12'd100) || (q_y[1:0] == 2'd0));
  assign len  = (s1_feb && leap) ? 5'd29 : s1_len;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_ok   <= s1_rng_ok && (s1_d != 5'd0) && (s1_d <= len);
      s2_y365 <= 21'(s1_yy) * 21'd365;
      s2_yy4  <= s1_yy[11:2];
      s2_q    <= q_yy;
      s2_doy  <= s1_doy;
    end
  end

  // stage 3: closed form day count
  logic [21:0] sum;
  logic [21:0] days_full;
  logic        s3_ok;
  logic [18:0] s3_days;

  assign sum = 22'(s2_y365) + 22'(s2_yy4) - 22'(s2_q) + 22'(s2_q[5:2]) + 22'(s2_doy);
  assign days_full = sum - d2ed_pkg::EPOCH_SHIFT;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_ok   <= s2_ok;
      s3_days <= days_full[18:0];
    end
  end

  // stage 4: divide by 7 product
  logic [18:0] wx;
  logic        s4_ok;
  logic [18:0] s4_days, s4_x;
  logic [38:0] s4_prod;

  assign wx = s3_days + d2ed_pkg::WEEK_OFFSET;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_ok   <= s3_ok;
      s4_days <= s3_days;
      s4_x    <= wx;
      s4_prod <= 39'(wx) * 39'(d2ed_pkg::DIV7_MUL);
    end
  end

  // stage 5: remainder and output register
  logic [16:0] q7;
  logic [18:0] rem7;

  assign q7   = s4_prod[38:22];
  assign rem7 = s4_x - 19'({q7, 3'b000} - 20'(q7));

  always_ff @(posedge clk) begin
    if (rdy5) begin
      date_ok    <= s4_ok;
      epoch_days <= s4_ok ? $signed(s4_days) : '0;
      weekday    <= s4_ok ? rem7[2:0] : '0;
    end
  end

endmodule
